/* src/awas_pkg.sv */
// Package for the Ackermann wheel angle split: formats, constants, atan table.
// No dependencies; used by every module of the block.
`default_nettype none
package awas_pkg;

  localparam int IFRAC = 30;            // internal angle fraction bits
  localparam int RXW   = 32;            // rotation CORDIC x/y width
  localparam int RZW   = 33;            // rotation CORDIC angle width
  localparam int PW    = 46;            // 14 x 32 product width
  localparam int VW    = 48;            // vectoring CORDIC x/y width
  localparam int VZW   = 35;            // vectoring CORDIC angle width
  localparam int TAB_LEN = 24;

  localparam logic signed [VZW-1:0] PI_Q      = VZW'(64'sd3373259426);
  localparam logic signed [RZW-1:0] HALF_PI_Q = RZW'(64'sd1686629713);
  localparam logic signed [RXW-1:0] UNIT_Q    = RXW'(64'sd268435456);

  typedef struct packed {
    logic zero;   // zero command, result forced to zero
    logic neg;    // negative command
  } awas_tag_t;

  // atan(2^-i), Q2.30, truncated
  function automatic logic [31:0] atan_q(input int i);
    logic [31:0] r;
    begin
      unique case (i)
        0:  r = 32'd843314856;
        1:  r = 32'd497837829;
        2:  r = 32'd263043836;
        3:  r = 32'd133525158;
        4:  r = 32'd67021686;
        5:  r = 32'd33543515;
        6:  r = 32'd16775850;
        7:  r = 32'd8388437;
        8:  r = 32'd4194282;
        9:  r = 32'd2097149;
        10: r = 32'd1048575;
        11: r = 32'd524287;
        12: r = 32'd262143;
        13: r = 32'd131071;
        14: r = 32'd65535;
        15: r = 32'd32767;
        16: r = 32'd16383;
        17: r = 32'd8191;
        18: r = 32'd4095;
        19: r = 32'd2047;
        20: r = 32'd1023;
        21: r = 32'd511;
        22: r = 32'd255;
        23: r = 32'd127;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

/* src/awas_rot.sv */
// Rotation CORDIC: steering command to cos/sin, one iteration per stage.
// Depends on awas_pkg.
`default_nettype none
module awas_rot #(
  parameter int CS  = 16,
  parameter int AFB = 13
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [14:0]          angle,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [awas_pkg::RXW-1:0]  cos_o,
  output logic signed [awas_pkg::RXW-1:0]  sin_o,
  output awas_pkg::awas_tag_t              tag_o
);
  import awas_pkg::*;

  localparam int SH = IFRAC - AFB;
  // wide enough for the shifted command and the half-pi limit at any AFB
  localparam int AW = 48;

  logic signed [RXW-1:0] x_q [0:CS];
  logic signed [RXW-1:0] y_q [0:CS];
  logic signed [RZW-1:0] z_q [0:CS];
  awas_tag_t             t_q [0:CS];
  logic [0:CS]           vld;
  logic [0:CS+1]         adv;

  logic signed [AW-1:0]  a_ext;
  logic signed [RZW-1:0] z_in;

  always_comb begin
    a_ext = AW'(angle) <<< SH;
    if (a_ext > AW'(HALF_PI_Q))       z_in = HALF_PI_Q;
    else if (a_ext < -AW'(HALF_PI_Q)) z_in = -HALF_PI_Q;
    else                              z_in = RZW'(a_ext);
  end

  assign adv[CS+1] = out_ready;
  assign in_ready  = adv[0];

  genvar k;
  generate
    for (k = 0; k <= CS; k++) begin : g_adv
      assign adv[k] = !vld[k] || adv[k+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv[0]) begin
      vld[0] <= in_valid;
    end
    if (adv[0] && in_valid) begin
      x_q[0] <= UNIT_Q;
      y_q[0] <= '0;
      z_q[0] <= z_in;
      t_q[0] <= '{zero: (angle == '0), neg: angle[14]};
    end
  end

  generate
    for (k = 1; k <= CS; k++) begin : g_step
      localparam int I = k - 1;
      logic signed [RXW-1:0] xs, ys;
      logic signed [RZW-1:0] at;
      assign xs = x_q[k-1] >>> I;
      assign ys = y_q[k-1] >>> I;
      assign at = $signed({1'b0, atan_q(I)});
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
        if (adv[k] && vld[k-1]) begin
          t_q[k] <= t_q[k-1];
          if (!z_q[k-1][RZW-1]) begin
            x_q[k] <= x_q[k-1] - ys;
            y_q[k] <= y_q[k-1] + xs;
            z_q[k] <= z_q[k-1] - at;
          end else begin
            x_q[k] <= x_q[k-1] + ys;
            y_q[k] <= y_q[k-1] - xs;
            z_q[k] <= z_q[k-1] + at;
          end
        end
      end
    end
  endgenerate

  assign out_valid = vld[CS];
  assign cos_o     = x_q[CS];
  assign sin_o     = y_q[CS];
  assign tag_o     = t_q[CS];

endmodule
`default_nettype wire

/* src/awas_mix.sv */
// Scales cos/sin by wheelbase and offset: multiply stage, then add stage.
// Depends on awas_pkg.
`default_nettype none
module awas_mix (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [awas_pkg::RXW-1:0] cos_i,
  input  wire logic signed [awas_pkg::RXW-1:0] sin_i,
  input  awas_pkg::awas_tag_t              tag_i,
  input  wire logic [12:0]                 wheelbase,
  input  wire logic [11:0]                 offset,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [awas_pkg::VW-1:0]   y_o,
  output logic signed [awas_pkg::VW-1:0]   xl_o,
  output logic signed [awas_pkg::VW-1:0]   xr_o,
  output awas_pkg::awas_tag_t              tag_o
);
  import awas_pkg::*;

  logic signed [PW-1:0] ls, lc, ws;
  awas_tag_t            t1;
  logic                 v1, v2;
  logic                 adv1, adv2;

  assign adv2     = !v2 || out_ready;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
    end
    if (adv1 && in_valid) begin
      ls <= $signed({1'b0, wheelbase}) * sin_i;
      lc <= $signed({1'b0, wheelbase}) * cos_i;
      ws <= $signed({2'b0, offset}) * sin_i;
      t1 <= tag_i;
    end
    if (adv2 && v1) begin
      y_o   <= VW'(ls);
      xl_o  <= VW'(lc) - VW'(ws);
      xr_o  <= VW'(lc) + VW'(ws);
      tag_o <= t1;
    end
  end

  assign out_valid = v2;

endmodule
`default_nettype wire

/* src/awas_vec.sv */
// Two-lane vectoring CORDIC (atan2) for left and right wheels, one step per stage.
// Depends on awas_pkg.
`default_nettype none
module awas_vec #(
  parameter int CS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [awas_pkg::VW-1:0] y_i,
  input  wire logic signed [awas_pkg::VW-1:0] xl_i,
  input  wire logic signed [awas_pkg::VW-1:0] xr_i,
  input  awas_pkg::awas_tag_t              tag_i,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [awas_pkg::VZW-1:0]  zl_o,
  output logic signed [awas_pkg::VZW-1:0]  zr_o,
  output awas_pkg::awas_tag_t              tag_o
);
  import awas_pkg::*;

  logic signed [VW-1:0]  x_q [0:CS][0:1];
  logic signed [VW-1:0]  y_q [0:CS][0:1];
  logic signed [VZW-1:0] z_q [0:CS][0:1];
  logic                  d_q [0:CS][0:1];   // quadrant case settled, no iteration
  awas_tag_t             t_q [0:CS];
  logic [0:CS]           vld;
  logic [0:CS+1]         adv;

  logic signed [VW-1:0]  xin [0:1];
  logic signed [VW-1:0]  x0 [0:1];
  logic signed [VW-1:0]  y0 [0:1];
  logic signed [VZW-1:0] z0 [0:1];
  logic                  d0 [0:1];

  assign xin[0] = xl_i;
  assign xin[1] = xr_i;

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      x0[j] = xin[j];
      y0[j] = y_i;
      z0[j] = '0;
      d0[j] = 1'b0;
      if (y_i == '0) begin
        d0[j] = 1'b1;
        if (xin[j][VW-1]) z0[j] = tag_i.neg ? -PI_Q : PI_Q;
      end else if (xin[j][VW-1]) begin
        z0[j] = y_i[VW-1] ? -PI_Q : PI_Q;
        x0[j] = -xin[j];
        y0[j] = -y_i;
      end
    end
  end

  assign adv[CS+1] = out_ready;
  assign in_ready  = adv[0];

  genvar k, j;
  generate
    for (k = 0; k <= CS; k++) begin : g_adv
      assign adv[k] = !vld[k] || adv[k+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv[0]) begin
      vld[0] <= in_valid;
    end
    if (adv[0] && in_valid) begin
      for (int n = 0; n < 2; n++) begin
        x_q[0][n] <= x0[n];
        y_q[0][n] <= y0[n];
        z_q[0][n] <= z0[n];
        d_q[0][n] <= d0[n];
      end
      t_q[0] <= tag_i;
    end
  end

  generate
    for (k = 1; k <= CS; k++) begin : g_step
      localparam int I = k - 1;
      logic signed [VZW-1:0] at;
      assign at = $signed({3'b0, atan_q(I)});

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
        if (adv[k] && vld[k-1]) begin
          t_q[k] <= t_q[k-1];
        end
      end

      for (j = 0; j < 2; j++) begin : g_lane
        logic signed [VW-1:0] xs, ys;
        logic                 ypos;
        assign xs   = x_q[k-1][j] >>> I;
        assign ys   = y_q[k-1][j] >>> I;
        assign ypos = !y_q[k-1][j][VW-1] && (y_q[k-1][j] != '0);
        always_ff @(posedge clk) begin
          if (adv[k] && vld[k-1]) begin
            d_q[k][j] <= d_q[k-1][j];
            if (d_q[k-1][j]) begin
              x_q[k][j] <= x_q[k-1][j];
              y_q[k][j] <= y_q[k-1][j];
              z_q[k][j] <= z_q[k-1][j];
            end else if (ypos) begin
              x_q[k][j] <= x_q[k-1][j] + ys;
              y_q[k][j] <= y_q[k-1][j] - xs;
              z_q[k][j] <= z_q[k-1][j] + at;
            end else begin
              x_q[k][j] <= x_q[k-1][j] - ys;
              y_q[k][j] <= y_q[k-1][j] + xs;
              z_q[k][j] <= z_q[k-1][j] - at;
            end
          end
        end
      end
    end
  endgenerate

  assign out_valid = vld[CS];
  assign zl_o      = z_q[CS][0];
  assign zr_o      = z_q[CS][1];
  assign tag_o     = t_q[CS];

endmodule
`default_nettype wire

/* src/ackermann_wheel_angle_split_top.sv */
// Ackermann wheel angle split, top level: config registers, CORDIC pipeline,
// rounding output register. Depends on awas_pkg, awas_rot, awas_mix, awas_vec.
//
//  channel  | handshake                  | payload
//  in       | in_valid / in_ready        | steer_cmd
//  out      | out_valid / out_ready      | left_wheel_angle, right_wheel_angle
//  cfg      | cfg_we (no wait)           | cfg_index, cfg_data
//
// One transaction per cycle sustained while out_ready stays high. Registered stages
// in order: input stage, rotation steps, two multiply/add stages, atan2 prep and steps,
// output register. Each stage holds while the one after it is full and stalled.
// Reset clears valid bits and loads wheelbase 2480 mm, offset 105 mm.
`default_nettype none
module ackermann_wheel_angle_split_top #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [14:0] steer_cmd,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      left_wheel_angle,
  output logic signed [15:0]      right_wheel_angle,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [12:0]        cfg_data
);
  import awas_pkg::*;

  localparam logic [1:0] REG_WHEELBASE = 2'd0;
  localparam logic [1:0] REG_OFFSET    = 2'd1;
  localparam int SH = IFRAC - ANGLE_FRAC_BITS;
  localparam logic signed [VZW:0] RND = (VZW+1)'(1) <<< (SH - 1);

  logic [12:0] wheelbase;
  logic [11:0] offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheelbase <= 13'd2480;
      offset    <= 12'd105;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WHEELBASE: wheelbase <= cfg_data;
        REG_OFFSET:    offset    <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  logic                  r_valid, r_ready, m_valid, m_ready, v_valid, v_ready;
  logic signed [RXW-1:0] c_w, s_w;
  awas_tag_t             r_tag, m_tag, v_tag;
  logic signed [VW-1:0]  y_w, xl_w, xr_w;
  logic signed [VZW-1:0] zl_w, zr_w;

  awas_rot #(.CS(CORDIC_STEPS), .AFB(ANGLE_FRAC_BITS)) u_rot (
    .clk, .rst, .in_valid, .in_ready, .angle(steer_cmd),
    .out_valid(r_valid), .out_ready(r_ready), .cos_o(c_w), .sin_o(s_w), .tag_o(r_tag)
  );

  awas_mix u_mix (
    .clk, .rst, .in_valid(r_valid), .in_ready(r_ready), .cos_i(c_w), .sin_i(s_w),
    .tag_i(r_tag), .wheelbase, .offset, .out_valid(m_valid), .out_ready(m_ready),
    .y_o(y_w), .xl_o(xl_w), .xr_o(xr_w), .tag_o(m_tag)
  );

  awas_vec #(.CS(CORDIC_STEPS)) u_vec (
    .clk, .rst, .in_valid(m_valid), .in_ready(m_ready), .y_i(y_w), .xl_i(xl_w),
    .xr_i(xr_w), .tag_i(m_tag), .out_valid(v_valid), .out_ready(v_ready),
    .zl_o(zl_w), .zr_o(zr_w), .tag_o(v_tag)
  );

  function automatic logic signed [15:0] to_out(input logic signed [VZW-1:0] z);
    logic signed [VZW:0] t;
    begin
      t = ((VZW+1)'(z) + RND) >>> SH;
      if (t > 32767)       return 16'sh7fff;
      else if (t < -32768) return 16'sh8000;
      else                 return t[15:0];
    end
  endfunction

  assign v_ready  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (v_ready) begin
      out_valid <= v_valid;
    end
    if (v_ready && v_valid) begin
      left_wheel_angle  <= v_tag.zero ? '0 : to_out(zl_w);
      right_wheel_angle <= v_tag.zero ? '0 : to_out(zr_w);
    end
  end

`ifndef ASSERT_OFF
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked with output side free");
  a_handoff: assert property (@(posedge clk) disable iff (rst)
    v_valid && v_ready |=> out_valid)
    else $error("result lost at output register");
`endif

endmodule
`default_nettype wire
